@@ design/lsfs_pkg.sv @@
// Shared constants, types and helpers of the LED strip frame serializer.
package lsfs_pkg;

  localparam int COLUMNS = 8;
  localparam int ROWS = 5;
  localparam int PIXELS = COLUMNS * ROWS;
  localparam int ADDR_W = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int PIXEL_W = 24;
  localparam int COL_W = 4;
  localparam int ROW_W = 3;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_START = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ONE_HIGH  = 3'd0,
    REG_ONE_LOW   = 3'd1,
    REG_ZERO_HIGH = 3'd2,
    REG_ZERO_LOW  = 3'd3,
    REG_LATCH     = 3'd4
  } reg_index_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_HIGH  = 2'd1,
    PH_LOW   = 2'd2,
    PH_LATCH = 2'd3
  } phase_t;

  typedef struct packed {
    logic               en;
    logic [ADDR_W-1:0]  addr;
    logic [PIXEL_W-1:0] data;
  } wr_req_t;

  function automatic logic [ADDR_W-1:0] pixel_addr(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] column);
    return ADDR_W'(int'(row) * COLUMNS + int'(column));
  endfunction

  function automatic logic [7:0] color_byte(input logic [PIXEL_W-1:0] pixel,
                                            input logic [1:0] color);
    logic [7:0] b;
    case (color)
      2'd0:    b = pixel[23:16];
      2'd1:    b = pixel[15:8];
      2'd2:    b = pixel[7:0];
      default: b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

@@ design/led_strip_frame_serializer.sv @@
// Top level of the single-wire LED strip frame serializer.
//
//   channel  beat                                      handshake
//   in       op, column, row, red, green, blue         in_valid / in_ready
//   out      line_level, busy_res, frame_done          out_valid / out_ready
//   cfg      cfg_index, cfg_data                       cfg_valid / cfg_ready
//
// One input beat is taken per clock whenever the output register is empty or being drained.
// Each result appears in the output register on the cycle after its input beat.
// A byte load reads the frame store; the read register feeds the bit logic on the next cycle.
// Reset clears all valid bits of the frame store at once, so no clearing sweep runs.
module led_strip_frame_serializer
  import lsfs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             op,
  input  logic [COL_W-1:0]       column,
  input  logic [ROW_W-1:0]       row,
  input  logic [7:0]             red,
  input  logic [7:0]             green,
  input  logic [7:0]             blue,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   line_level,
  output logic                   busy_res,
  output logic                   frame_done,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [7:0]  one_high_ticks;
  logic [7:0]  one_low_ticks;
  logic [7:0]  zero_high_ticks;
  logic [7:0]  zero_low_ticks;
  logic [15:0] latch_ticks;

  phase_t             phase, phase_next;
  logic [ADDR_W-1:0]  pixel_index, pixel_index_next;
  logic [1:0]         color_index, color_index_next;
  logic [2:0]         bit_index, bit_index_next;
  logic [7:0]         bit_shift, bit_shift_next;
  logic [15:0]        tick_count, tick_count_next;
  logic               pending;

  logic               in_fire;
  logic               load;
  logic               done;
  logic [7:0]         cur_shift;
  logic [15:0]        tick_inc;
  logic [15:0]        high_lim;
  logic [15:0]        low_lim;
  logic [15:0]        latch_lim;
  logic [7:0]         high_raw;
  logic [7:0]         low_raw;
  wr_req_t            wr;
  logic [PIXEL_W-1:0] rd_data;
  logic               res_line;
  logic               res_busy;
  logic               res_done;

  assign in_ready = !out_valid || out_ready;
  assign in_fire = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      one_high_ticks <= 8'd8;
      one_low_ticks <= 8'd6;
      zero_high_ticks <= 8'd4;
      zero_low_ticks <= 8'd8;
      latch_ticks <= 16'd960;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_index_t'(cfg_index))
        REG_ONE_HIGH:  one_high_ticks <= cfg_data[7:0];
        REG_ONE_LOW:   one_low_ticks <= cfg_data[7:0];
        REG_ZERO_HIGH: zero_high_ticks <= cfg_data[7:0];
        REG_ZERO_LOW:  zero_low_ticks <= cfg_data[7:0];
        REG_LATCH:     latch_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  lsfs_frame_store u_store (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .rd_en   (load),
    .rd_addr (pixel_index_next),
    .rd_data (rd_data)
  );

  // The byte of a fresh load comes from the read register until it is captured.
  assign cur_shift = pending ? color_byte(rd_data, color_index) : bit_shift;
  assign tick_inc = tick_count + 16'd1;
  assign high_raw = cur_shift[7] ? one_high_ticks : zero_high_ticks;
  assign low_raw = cur_shift[7] ? one_low_ticks : zero_low_ticks;
  assign high_lim = (high_raw == 8'd0) ? 16'd1 : {8'd0, high_raw};
  assign low_lim = (low_raw == 8'd0) ? 16'd1 : {8'd0, low_raw};
  assign latch_lim = (latch_ticks == 16'd0) ? 16'd1 : latch_ticks;

  always_comb begin
    phase_next = phase;
    pixel_index_next = pixel_index;
    color_index_next = color_index;
    bit_index_next = bit_index;
    bit_shift_next = cur_shift;
    tick_count_next = tick_count;
    load = 1'b0;
    done = 1'b0;
    wr = '0;
    if (in_fire) begin
      case (op_t'(op))
        OP_WRITE: begin
          if (int'(column) < COLUMNS && int'(row) < ROWS) begin
            wr.en = 1'b1;
            wr.addr = pixel_addr(row, column);
            wr.data = {green, red, blue};
          end
        end
        OP_START: begin
          if (phase == PH_IDLE) begin
            pixel_index_next = '0;
            color_index_next = 2'd0;
            bit_index_next = 3'd0;
            tick_count_next = 16'd0;
            load = 1'b1;
            phase_next = PH_HIGH;
          end
        end
        OP_TICK: begin
          case (phase)
            PH_HIGH: begin
              tick_count_next = tick_inc;
              if (tick_inc >= high_lim) begin
                phase_next = PH_LOW;
                tick_count_next = 16'd0;
              end
            end
            PH_LOW: begin
              tick_count_next = tick_inc;
              if (tick_inc >= low_lim) begin
                tick_count_next = 16'd0;
                bit_shift_next = {cur_shift[6:0], 1'b0};
                if (bit_index < 3'd7) begin
                  bit_index_next = bit_index + 3'd1;
                  phase_next = PH_HIGH;
                end else begin
                  bit_index_next = 3'd0;
                  if (color_index < 2'd2) begin
                    color_index_next = color_index + 2'd1;
                    load = 1'b1;
                    phase_next = PH_HIGH;
                  end else begin
                    color_index_next = 2'd0;
                    if (pixel_index != ADDR_W'(PIXELS - 1)) begin
                      pixel_index_next = pixel_index + ADDR_W'(1);
                      load = 1'b1;
                      phase_next = PH_HIGH;
                    end else begin
                      pixel_index_next = '0;
                      phase_next = PH_LATCH;
                    end
                  end
                end
              end
            end
            PH_LATCH: begin
              tick_count_next = tick_inc;
              if (tick_inc >= latch_lim) begin
                tick_count_next = 16'd0;
                phase_next = PH_IDLE;
                done = 1'b1;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res_line = (phase_next == PH_HIGH);
    res_busy = (phase_next != PH_IDLE);
    res_done = done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      pixel_index <= '0;
      color_index <= 2'd0;
      bit_index <= 3'd0;
      bit_shift <= 8'd0;
      tick_count <= 16'd0;
      pending <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      pixel_index <= pixel_index_next;
      color_index <= color_index_next;
      bit_index <= bit_index_next;
      bit_shift <= bit_shift_next;
      tick_count <= tick_count_next;
      pending <= load;
      if (in_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      line_level <= res_line;
      busy_res <= res_busy;
      frame_done <= res_done;
    end
  end

`ifndef SYNTH
  a_load_not_back_to_back: assert property (@(posedge clk) disable iff (rst)
    pending |=> !pending)
    else $error("byte loads on consecutive cycles");

  a_idle_count_clear: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> tick_count == 16'd0)
    else $error("tick count not clear while idle");

  a_line_implies_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && line_level |-> busy_res && !frame_done)
    else $error("line high outside a running frame");
`endif

endmodule

@@ design/lsfs_frame_store.sv @@
// Pixel memory with one write port, one registered read port and per-entry valid bits.
module lsfs_frame_store
  import lsfs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  wr_req_t            wr,
  input  logic               rd_en,
  input  logic [ADDR_W-1:0]  rd_addr,
  output logic [PIXEL_W-1:0] rd_data
);

  logic [PIXEL_W-1:0] mem [PIXELS];
  logic [PIXELS-1:0]  valid;
  logic [PIXEL_W-1:0] rword;
  logic               rvalid;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rword <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      rvalid <= 1'b0;
    end else begin
      if (wr.en) begin
        valid[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        rvalid <= valid[rd_addr];
      end
    end
  end

  assign rd_data = rvalid ? rword : '0;

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the LED strip frame serializer: directed and random beats against a line model.
`timescale 1ns / 1ps

module tb_top
  import lsfs_pkg::*;
;

  localparam logic [1:0] OP_UNDEFINED = 2'd3;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 16;

  typedef struct packed {
    logic level;
    logic busy;
    logic done;
  } line_beat_t;

  class waveform_board;
    line_beat_t pending_beats[$];
    logic [PIXEL_W-1:0] pixels[PIXELS];
    int pixel_no;
    logic [1:0] color_no;
    logic [2:0] bit_no;
    logic [7:0] shift_byte;
    phase_t phase;
    logic [15:0] tick_cnt;
    logic [7:0] one_high;
    logic [7:0] one_low;
    logic [7:0] zero_high;
    logic [7:0] zero_low;
    logic [15:0] latch_len;
    int errors;
    int reported;

    function new();
      foreach (pixels[i]) pixels[i] = '0;
      pixel_no = 0;
      color_no = '0;
      bit_no = '0;
      shift_byte = '0;
      phase = PH_IDLE;
      tick_cnt = '0;
      one_high = 8'd8;
      one_low = 8'd6;
      zero_high = 8'd4;
      zero_low = 8'd8;
      latch_len = 16'd960;
      errors = 0;
      reported = 0;
    endfunction

    function void report(string msg);
      errors++;
      if (reported < 10) begin
        reported++;
        $display("mismatch at %0t: %s", $realtime, msg);
      end
    endfunction

    function int pending_count();
      return pending_beats.size();
    endfunction

    function bit busy();
      return phase != PH_IDLE;
    endfunction

    function void load_color();
      logic [PIXEL_W-1:0] px;
      px = pixels[pixel_no];
      case (color_no)
        2'd0:    shift_byte = px[23:16];
        2'd1:    shift_byte = px[15:8];
        2'd2:    shift_byte = px[7:0];
        default: shift_byte = 8'd0;
      endcase
    endfunction

    function bit reached(input logic [15:0] lim);
      logic [15:0] eff;
      tick_cnt = tick_cnt + 16'd1;
      eff = (lim == 16'd0) ? 16'd1 : lim;
      return tick_cnt >= eff;
    endfunction

    function void note_config(input logic [CFG_INDEX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_ONE_HIGH:  one_high = data[7:0];
        REG_ONE_LOW:   one_low = data[7:0];
        REG_ZERO_HIGH: zero_high = data[7:0];
        REG_ZERO_LOW:  zero_low = data[7:0];
        REG_LATCH:     latch_len = data;
        default: ;
      endcase
    endfunction

    function void take_item(input logic [1:0] code, input logic [COL_W-1:0] col,
                            input logic [ROW_W-1:0] rw, input logic [7:0] r_val,
                            input logic [7:0] g_val, input logic [7:0] b_val);
      logic done;
      logic [15:0] lim;
      line_beat_t beat;
      done = 1'b0;
      case (code)
        OP_WRITE: begin
          if (int'(col) < COLUMNS && int'(rw) < ROWS)
            pixels[int'(rw) * COLUMNS + int'(col)] = {g_val, r_val, b_val};
        end
        OP_START: begin
          if (phase == PH_IDLE) begin
            pixel_no = 0;
            color_no = '0;
            bit_no = '0;
            tick_cnt = '0;
            load_color();
            phase = PH_HIGH;
          end
        end
        OP_TICK: begin
          case (phase)
            PH_HIGH: begin
              lim = shift_byte[7] ? {8'd0, one_high} : {8'd0, zero_high};
              if (reached(lim)) begin
                phase = PH_LOW;
                tick_cnt = '0;
              end
            end
            PH_LOW: begin
              lim = shift_byte[7] ? {8'd0, one_low} : {8'd0, zero_low};
              if (reached(lim)) begin
                tick_cnt = '0;
                shift_byte = shift_byte << 1;
                if (bit_no < 3'd7) begin
                  bit_no++;
                  phase = PH_HIGH;
                end else begin
                  bit_no = '0;
                  if (color_no < 2'd2) begin
                    color_no++;
                    load_color();
                    phase = PH_HIGH;
                  end else begin
                    color_no = '0;
                    if (pixel_no + 1 < PIXELS) begin
                      pixel_no++;
                      load_color();
                      phase = PH_HIGH;
                    end else begin
                      pixel_no = 0;
                      phase = PH_LATCH;
                    end
                  end
                end
              end
            end
            PH_LATCH: begin
              if (reached(latch_len)) begin
                tick_cnt = '0;
                phase = PH_IDLE;
                done = 1'b1;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
      beat.level = (phase == PH_HIGH);
      beat.busy = (phase != PH_IDLE);
      beat.done = done;
      pending_beats.push_back(beat);
    endfunction

    function void check_beat(input logic level, input logic busy_now, input logic done);
      line_beat_t want;
      if (pending_beats.size() == 0) begin
        report($sformatf("result with nothing pending: level %0b busy %0b done %0b",
                         level, busy_now, done));
        return;
      end
      want = pending_beats.pop_front();
      if (want.level !== level || want.busy !== busy_now || want.done !== done)
        report($sformatf("level exp %0b got %0b, busy exp %0b got %0b, done exp %0b got %0b",
                         want.level, level, want.busy, busy_now, want.done, done));
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] op = OP_WRITE;
  logic [COL_W-1:0] column = '0;
  logic [ROW_W-1:0] row = '0;
  logic [7:0] red = '0;
  logic [7:0] green = '0;
  logic [7:0] blue = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic line_level;
  logic busy_res;
  logic frame_done;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  waveform_board wave_board = new();
  int idle_pct = 0;
  int stall_pct = 0;
  int cycle_count = 0;

  led_strip_frame_serializer dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .op(op),
    .column(column),
    .row(row),
    .red(red),
    .green(green),
    .blue(blue),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .line_level(line_level),
    .busy_res(busy_res),
    .frame_done(frame_done),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL led_strip_frame_serializer");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      wave_board.check_beat(line_level, busy_res, frame_done);
  end

  initial begin
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  task automatic send_beat(input logic [1:0] code, input logic [COL_W-1:0] col,
                           input logic [ROW_W-1:0] rw, input logic [7:0] r_val,
                           input logic [7:0] g_val, input logic [7:0] b_val);
    in_valid <= 1'b1;
    op <= code;
    column <= col;
    row <= rw;
    red <= r_val;
    green <= g_val;
    blue <= b_val;
    do @(posedge clk); while (!in_ready);
    wave_board.take_item(code, col, rw, r_val, g_val, b_val);
  endtask

  task automatic maybe_idle();
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (wave_board.pending_count() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    wave_board.note_config(idx, data);
  endtask

  task automatic load_timing(input logic [7:0] oh, input logic [7:0] ol, input logic [7:0] zh,
                             input logic [7:0] zl, input logic [15:0] latch);
    write_reg(REG_ONE_HIGH, {8'($urandom), oh});
    write_reg(REG_ONE_LOW, {8'($urandom), ol});
    write_reg(REG_ZERO_HIGH, {8'($urandom), zh});
    write_reg(REG_ZERO_LOW, {8'($urandom), zl});
    write_reg(REG_LATCH, latch);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_color();
    int pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return 8'h00;
    if (pick == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  task automatic send_random_beat();
    int pick;
    logic [1:0] code;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] rw;
    pick = $urandom_range(0, 99);
    col = COL_W'($urandom_range(0, 15));
    rw = ROW_W'($urandom_range(0, 7));
    if (pick < 68) begin
      code = OP_TICK;
    end else if (pick < 88) begin
      code = OP_WRITE;
      if ($urandom_range(0, 3) != 0) begin
        col = COL_W'($urandom_range(0, COLUMNS - 1));
        rw = ROW_W'($urandom_range(0, ROWS - 1));
      end
    end else if (pick < 96) begin
      code = OP_START;
    end else begin
      code = OP_UNDEFINED;
    end
    send_beat(code, col, rw, pick_color(), pick_color(), pick_color());
  endtask

  task automatic run_phase(input int count);
    repeat (count) begin
      send_random_beat();
      maybe_idle();
    end
    drain_results();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    idle_pct = 25;
    stall_pct = 25;
    send_beat(OP_TICK, '0, '0, '0, '0, '0);
    send_beat(OP_UNDEFINED, 4'd15, 3'd7, 8'hFF, 8'hFF, 8'hFF);
    send_beat(OP_WRITE, 4'd0, 3'd0, 8'hFF, 8'hFF, 8'hFF);
    maybe_idle();
    send_beat(OP_WRITE, 4'(COLUMNS - 1), 3'(ROWS - 1), 8'h00, 8'h00, 8'h00);
    send_beat(OP_WRITE, 4'(COLUMNS - 1), 3'd0, 8'hA5, 8'h5A, 8'hC3);
    send_beat(OP_WRITE, 4'd0, 3'(ROWS - 1), 8'h0F, 8'hF0, 8'h81);
    send_beat(OP_WRITE, 4'(COLUMNS), 3'd0, 8'h11, 8'h22, 8'h33);
    send_beat(OP_WRITE, 4'd15, 3'd7, 8'h44, 8'h55, 8'h66);
    send_beat(OP_WRITE, 4'd3, 3'(ROWS), 8'h77, 8'h88, 8'h99);
    maybe_idle();
    send_beat(OP_START, '0, '0, '0, '0, '0);
    send_beat(OP_START, 4'd15, 3'd7, 8'hFF, 8'hFF, 8'hFF);
    repeat (4) send_beat(OP_TICK, '0, '0, '0, '0, '0);
    send_beat(OP_WRITE, 4'd0, 3'd0, 8'h00, 8'h80, 8'h01);
    send_beat(OP_WRITE, 4'd1, 3'd0, 8'hFE, 8'h7F, 8'h3C);
    maybe_idle();
    repeat (3) send_beat(OP_TICK, '0, '0, '0, '0, '0);
    send_beat(OP_UNDEFINED, '0, '0, '0, '0, '0);
    repeat (2) send_beat(OP_TICK, '0, '0, '0, '0, '0);
    drain_results();

    write_reg(CFG_INDEX_W'($urandom_range(int'(REG_LATCH) + 1, (1 << CFG_INDEX_W) - 1)),
              16'($urandom));
    load_timing(8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)),
                8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)),
                16'($urandom_range(1, 40)));
    idle_pct = 30;
    stall_pct = 30;
    run_phase(220);

    load_timing(8'd2, 8'd0, 8'd0, 8'd1, 16'd0);
    idle_pct = 15;
    stall_pct = 15;
    run_phase(200);

    load_timing(8'd255, 8'd255, 8'd255, 8'd255, 16'hFFFF);
    idle_pct = 10;
    stall_pct = 40;
    run_phase(150);

    load_timing(8'($urandom_range(1, 255)), 8'($urandom_range(1, 12)),
                8'($urandom_range(1, 12)), 8'($urandom_range(1, 12)),
                16'($urandom_range(1, 65535)));
    load_timing(8'($urandom_range(1, 12)), 8'($urandom_range(1, 12)),
                8'($urandom_range(1, 12)), 8'($urandom_range(1, 12)),
                16'($urandom_range(1, 30)));
    idle_pct = 20;
    stall_pct = 20;
    run_phase(250);

    load_timing(8'd1, 8'd1, 8'd1, 8'd1, 16'd1);
    idle_pct = 0;
    stall_pct = 0;
    run_phase(250);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (wave_board.errors == 0)
      $display("PASS led_strip_frame_serializer");
    else
      $display("FAIL led_strip_frame_serializer");
    $finish;
  end

endmodule

@@ files.f @@
design/lsfs_pkg.sv
design/lsfs_frame_store.sv
design/led_strip_frame_serializer.sv
tb/tb_top.sv
